FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with active-low rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CCC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccc assertion failed");

// implication with a fixed delay in cycles
`define CCC_ASSERT_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("ccc latency assertion failed");

`endif

FILE: sv/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Types, calibration windows and reciprocal constants for the color classifier
// ----------------------------------------------------------------------------
package ccc_pkg;

    // channel layout
    localparam int unsigned NUM_CH   = 4;
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;
    localparam int unsigned CH_CLEAR = 3;

    localparam int unsigned RAW_W   = 16;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned SPAN_W  = 10;  // clamped count minus white, max 928
    localparam int unsigned NUM_W   = 18;  // span * 255, max 236640
    localparam int unsigned RECIP_W = 19;
    localparam int unsigned PROD_W  = NUM_W + RECIP_W;
    localparam int unsigned RECIP_SHIFT = 28;

    // config register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MARGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_HIGH    = 2'd2;

    localparam logic [LEVEL_W-1:0] COLOR_MARGIN_RST = 8'd15;
    localparam logic [LEVEL_W-1:0] DARK_LOW_RST     = 8'd25;
    localparam logic [LEVEL_W-1:0] DARK_HIGH_RST    = 8'd100;

    typedef logic [RAW_W-1:0]   raw_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef raw_t   [NUM_CH-1:0] raw_vec_t;
    typedef level_t [NUM_CH-1:0] level_vec_t;

    typedef struct packed {
        level_t color_margin;
        level_t dark_low;
        level_t dark_high;
    } cfg_t;

    typedef enum logic [2:0] {
        CLS_RED   = 3'd0,
        CLS_GREEN = 3'd1,
        CLS_BLUE  = 3'd2,
        CLS_DARK  = 3'd3,
        CLS_NONE  = 3'd4
    } class_t;

    // calibration windows, white and black ends
    localparam raw_t WIN_LO [NUM_CH] = '{16'd15,  16'd22,  16'd130, 16'd21};
    localparam raw_t WIN_HI [NUM_CH] = '{16'd927, 16'd950, 16'd800, 16'd750};

    // ceil(2^28 / span); exact floor division since numerator * error < 2^28
    localparam logic [63:0] RECIP_RED   = ((64'd1 << RECIP_SHIFT) + 64'd911) / 64'd912;
    localparam logic [63:0] RECIP_GREEN = ((64'd1 << RECIP_SHIFT) + 64'd927) / 64'd928;
    localparam logic [63:0] RECIP_BLUE  = ((64'd1 << RECIP_SHIFT) + 64'd669) / 64'd670;
    localparam logic [63:0] RECIP_CLEAR = ((64'd1 << RECIP_SHIFT) + 64'd728) / 64'd729;

    localparam logic [RECIP_W-1:0] RECIP [NUM_CH] = '{
        RECIP_RED[RECIP_W-1:0],
        RECIP_GREEN[RECIP_W-1:0],
        RECIP_BLUE[RECIP_W-1:0],
        RECIP_CLEAR[RECIP_W-1:0]
    };

endpackage

FILE: sv/ccc_scaler.sv
// ----------------------------------------------------------------------------
// ccc_scaler
// Clamps each raw count to its window and scales it to 0..255, registered
// ----------------------------------------------------------------------------
module ccc_scaler
    import ccc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  raw_vec_t   raw,
    output logic       out_valid,
    output level_vec_t level
);

    level_vec_t level_next;
    level_vec_t level_reg;
    logic       valid_reg;

    // one lane per channel: clamp, subtract white, times 255, reciprocal divide
    for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
        raw_t                clamped;
        logic [SPAN_W-1:0]   span;
        logic [NUM_W-1:0]    numer;
        logic [PROD_W-1:0]   prod;

        always_comb
        begin
            if (raw[i] < WIN_LO[i])
            begin
                clamped = WIN_LO[i];
            end
            else if (raw[i] > WIN_HI[i])
            begin
                clamped = WIN_HI[i];
            end
            else
            begin
                clamped = raw[i];
            end
            span  = SPAN_W'(clamped - WIN_LO[i]);
            numer = (NUM_W'(span) << LEVEL_W) - NUM_W'(span);
            prod  = PROD_W'(numer) * PROD_W'(RECIP[i]);
            level_next[i] = prod[RECIP_SHIFT +: LEVEL_W];
        end
    end

    // scaled level register
    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign level     = level_reg;

endmodule

FILE: sv/ccc_classify.sv
// ----------------------------------------------------------------------------
// ccc_classify
// Picks the dominant color or dark from scaled levels, registered result
// ----------------------------------------------------------------------------
module ccc_classify
    import ccc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  level_vec_t level,
    input  cfg_t       cfg,
    output logic       result_valid,
    output logic [2:0] color_class
);

    class_t class_next;
    class_t class_reg;
    logic   result_valid_reg;

    logic [LEVEL_W:0] r_m, g_m, b_m;
    logic [LEVEL_W:0] r_x, g_x, b_x;
    logic             red_wins, green_wins, blue_wins, is_dark;

    // margin compares done one bit wider so they never wrap
    always_comb
    begin
        r_x = {1'b0, level[CH_RED]};
        g_x = {1'b0, level[CH_GREEN]};
        b_x = {1'b0, level[CH_BLUE]};
        r_m = r_x + {1'b0, cfg.color_margin};
        g_m = g_x + {1'b0, cfg.color_margin};
        b_m = b_x + {1'b0, cfg.color_margin};

        red_wins   = (r_x > g_m) && (r_x > b_m);
        green_wins = (g_x > r_m) && (g_x > b_m);
        blue_wins  = (b_x > r_m) && (b_x > g_m);
        is_dark    = (level[CH_CLEAR] > cfg.dark_low) && (level[CH_CLEAR] < cfg.dark_high);

        // priority red, green, blue, then dark
        if (red_wins)
        begin
            class_next = CLS_RED;
        end
        else if (green_wins)
        begin
            class_next = CLS_GREEN;
        end
        else if (blue_wins)
        begin
            class_next = CLS_BLUE;
        end
        else if (is_dark)
        begin
            class_next = CLS_DARK;
        end
        else
        begin
            class_next = CLS_NONE;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= in_valid;
        end
    end

    assign result_valid = result_valid_reg;
    assign color_class  = class_reg;

endmodule

FILE: sv/calibrated_color_classifier_unit.sv
// Throughput: one item per cycle; busy stays low and start may be held high.
// Pipeline: input register, clamp-and-scale register (one reciprocal multiply
// per channel), classify register. The receiver cannot stall the result.
// Reset (rst_n, async low) empties the pipeline and restores margin 15,
// dark limits 25 and 100.
// ----------------------------------------------------------------------------
// calibrated_color_classifier_unit
// Classifies calibrated RGB-clear sensor readings into a color class
// ----------------------------------------------------------------------------
module calibrated_color_classifier_unit
    import ccc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          red_raw,
    input  logic [15:0]          green_raw,
    input  logic [15:0]          blue_raw,
    input  logic [15:0]          clear_raw,
    output logic                 result_valid,
    output logic [2:0]           color_class,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    raw_vec_t   raw_reg;
    logic       in_valid_reg;
    logic       accept;
    logic       scaled_valid;
    level_vec_t scaled;
    cfg_t       cfg_reg;

    // pipeline never backs up, so items are always taken
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // input item register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg[CH_RED]   <= red_raw;
            raw_reg[CH_GREEN] <= green_raw;
            raw_reg[CH_BLUE]  <= blue_raw;
            raw_reg[CH_CLEAR] <= clear_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    // configuration registers, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_margin <= COLOR_MARGIN_RST;
            cfg_reg.dark_low     <= DARK_LOW_RST;
            cfg_reg.dark_high    <= DARK_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COLOR_MARGIN: cfg_reg.color_margin <= cfg_data;
                REG_DARK_LOW:     cfg_reg.dark_low     <= cfg_data;
                REG_DARK_HIGH:    cfg_reg.dark_high    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp and scale stage
    ccc_scaler u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .raw       (raw_reg),
        .out_valid (scaled_valid),
        .level     (scaled)
    );

    // classify stage
    ccc_classify u_classify (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (scaled_valid),
        .level        (scaled),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .color_class  (color_class)
    );

endmodule

FILE: sv/ccc_checker.sv
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level timing and code checks for the color classifier
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccc_checker
    import ccc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [2:0] color_class,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // every accepted item gives its result once through the input, scale and classify registers
    `CCC_ASSERT_DLY(a_latency, start && !busy, 3, result_valid)

    // no result without an item accepted ahead of it through the input, scale and classify registers
    `CCC_ASSERT_IMP(a_no_phantom, result_valid, $past(start && !busy, 3))

    // a delivered class is one of the five defined codes
    `CCC_ASSERT_IMP(a_class_code, result_valid, color_class <= CLS_NONE)

    // config writes never wait, whatever the index
    `CCC_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind calibrated_color_classifier_unit ccc_checker u_ccc_checker (.*);

FILE: tb/tb_calibrated_color_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_calibrated_color_classifier_unit
// Self-checking bench for the color classifier. Readings are queued by the
// stimulus process, driven by a clocked driver and classified by a local
// predictor when they are accepted. A monitor checks each result strobe in
// order. Thresholds are rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_calibrated_color_classifier_unit
    import ccc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 6;
    // index past the last register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // calibration windows, low and high ends
    localparam int unsigned RED_WIN_LO   = 15;
    localparam int unsigned RED_WIN_HI   = 927;
    localparam int unsigned GREEN_WIN_LO = 22;
    localparam int unsigned GREEN_WIN_HI = 950;
    localparam int unsigned BLUE_WIN_LO  = 130;
    localparam int unsigned BLUE_WIN_HI  = 800;
    localparam int unsigned CLEAR_WIN_LO = 21;
    localparam int unsigned CLEAR_WIN_HI = 750;
    localparam int unsigned FULL_SCALE   = 255;

    typedef struct packed {
        raw_t red;
        raw_t green;
        raw_t blue;
        raw_t clear;
    } reading_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [15:0]          red_raw      = '0;
    logic [15:0]          green_raw    = '0;
    logic [15:0]          blue_raw     = '0;
    logic [15:0]          clear_raw    = '0;
    logic                 result_valid;
    logic [2:0]           color_class;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [7:0]           cfg_data     = '0;

    reading_t    pending_readings[$];
    class_t      expected_classes[$];
    reading_t    driven_reading = '0;
    int unsigned sender_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // local copy of the thresholds
    level_t margin_now    = COLOR_MARGIN_RST;
    level_t dark_low_now  = DARK_LOW_RST;
    level_t dark_high_now = DARK_HIGH_RST;

    calibrated_color_classifier_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .red_raw      (red_raw),
        .green_raw    (green_raw),
        .blue_raw     (blue_raw),
        .clear_raw    (clear_raw),
        .result_valid (result_valid),
        .color_class  (color_class),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // clamp a raw count to its window and stretch it to 0..255
    function automatic int unsigned scale_count(raw_t raw, int unsigned white,
                                                int unsigned black);
        int unsigned x;
        x = raw;
        if (x < white)
            x = white;
        if (x > black)
            x = black;
        return ((x - white) * FULL_SCALE) / (black - white);
    endfunction

    function automatic bit wins_by_margin(int unsigned a, int unsigned b, int unsigned c);
        return (a > b + margin_now) && (a > c + margin_now);
    endfunction

    function automatic class_t classify_reading(reading_t rd);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned c;
        r = scale_count(rd.red, RED_WIN_LO, RED_WIN_HI);
        g = scale_count(rd.green, GREEN_WIN_LO, GREEN_WIN_HI);
        b = scale_count(rd.blue, BLUE_WIN_LO, BLUE_WIN_HI);
        c = scale_count(rd.clear, CLEAR_WIN_LO, CLEAR_WIN_HI);
        if (wins_by_margin(r, g, b))
            return CLS_RED;
        if (wins_by_margin(g, r, b))
            return CLS_GREEN;
        if (wins_by_margin(b, r, g))
            return CLS_BLUE;
        if (c > dark_low_now && c < dark_high_now)
            return CLS_DARK;
        return CLS_NONE;
    endfunction

    // count around a window, now and then anywhere in 16 bits
    function automatic raw_t rand_count(int unsigned black);
        if ($urandom_range(99) < 15)
            return raw_t'($urandom_range(65535));
        return raw_t'($urandom_range(black + 40, 0));
    endfunction

    // mostly one channel pushed up against the others, the rest plain random
    function automatic reading_t rand_reading();
        reading_t    rd;
        int unsigned lead;
        rd.red   = rand_count(RED_WIN_HI);
        rd.green = rand_count(GREEN_WIN_HI);
        rd.blue  = rand_count(BLUE_WIN_HI);
        rd.clear = rand_count(CLEAR_WIN_HI);
        lead = $urandom_range(4);
        case (lead)
            0: rd.red   = raw_t'($urandom_range(RED_WIN_HI + 10, RED_WIN_HI / 2));
            1: rd.green = raw_t'($urandom_range(GREEN_WIN_HI + 10, GREEN_WIN_HI / 2));
            2: rd.blue  = raw_t'($urandom_range(BLUE_WIN_HI + 10, BLUE_WIN_HI / 2));
            default: ;
        endcase
        return rd;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_reading(raw_t r, raw_t g, raw_t b, raw_t c);
        reading_t rd;
        rd.red   = r;
        rd.green = g;
        rd.blue  = b;
        rd.clear = c;
        pending_readings.push_back(rd);
    endtask

    task automatic add_random_readings(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            pending_readings.push_back(rand_reading());
    endtask

    // write one threshold register over the config channel
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, level_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COLOR_MARGIN: margin_now    = value;
            REG_DARK_LOW:     dark_low_now  = value;
            REG_DARK_HIGH:    dark_high_now = value;
            default: ;
        endcase
    endtask

    // hold the sender until the queue is empty and every result is back,
    // looked at mid-cycle so the edge updates have all landed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_readings.size() != 0 || start || expected_classes.size() != 0);
    endtask

    // driver: predict on accept, then present the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        reading_t rd;
        bit       accepted;
        if (!rst_n)
        begin
            start     <= 1'b0;
            red_raw   <= '0;
            green_raw <= '0;
            blue_raw  <= '0;
            clear_raw <= '0;
        end
        else
        begin
            accepted = start && !busy;
            if (accepted)
                expected_classes.push_back(classify_reading(driven_reading));
            if (!start || accepted)
            begin
                if (pending_readings.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    rd = pending_readings.pop_front();
                    driven_reading = rd;
                    red_raw   <= rd.red;
                    green_raw <= rd.green;
                    blue_raw  <= rd.blue;
                    clear_raw <= rd.clear;
                    start     <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each strobe against the oldest expected class
    always @(posedge clk)
    begin
        class_t want;
        if (rst_n && result_valid)
        begin
            if (expected_classes.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no item outstanding", color_class));
            end
            else
            begin
                want = expected_classes.pop_front();
                if (color_class !== want)
                    report_mismatch($sformatf("color_class got %0d want %0d (%s)",
                                              color_class, want, want.name()));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_calibrated_color_classifier_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        level_t lo;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset thresholds: directed corners, then random
        sender_idle_pct = 22;
        add_reading(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_reading(16'd927, 16'd22, 16'd130, 16'd21);
        add_reading(16'd15, 16'd950, 16'd130, 16'd21);
        add_reading(16'd15, 16'd22, 16'd800, 16'd21);
        add_reading(16'd200, 16'd200, 16'd200, 16'd200);
        // clear right at and just inside each dark limit
        add_reading(16'd0, 16'd0, 16'd0, 16'd93);
        add_reading(16'd0, 16'd0, 16'd0, 16'd96);
        add_reading(16'd0, 16'd0, 16'd0, 16'd306);
        add_reading(16'd0, 16'd0, 16'd0, 16'd307);
        // window ends and just outside them
        add_reading(16'd15, 16'd22, 16'd130, 16'd21);
        add_reading(16'd14, 16'd21, 16'd129, 16'd20);
        add_reading(16'd928, 16'd951, 16'd801, 16'd751);
        add_reading(16'hFFFF, 16'h0000, 16'h0000, 16'd200);
        add_reading(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        add_reading(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        add_reading(16'hFFFF, 16'hFFFF, 16'h0000, 16'd200);
        add_reading(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        add_reading(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        add_random_readings(150);
        wait_drained();

        // zero margin, widest dark band, plus a dropped write
        write_reg(REG_COLOR_MARGIN, 8'd0);
        write_reg(REG_DARK_LOW, 8'd0);
        write_reg(REG_DARK_HIGH, 8'd255);
        write_reg(REG_UNUSED, level_t'($urandom_range(255)));
        add_reading(16'd471, 16'd497, 16'd465, 16'd385);
        add_reading(16'd0, 16'd0, 16'd0, 16'd22);
        add_reading(16'd0, 16'd0, 16'd0, 16'd749);
        add_random_readings(150);
        wait_drained();

        // widest margin and an empty dark band
        sender_idle_pct = 47;
        write_reg(REG_COLOR_MARGIN, 8'd255);
        write_reg(REG_DARK_LOW, 8'd254);
        write_reg(REG_DARK_HIGH, 8'd255);
        add_reading(16'hFFFF, 16'h0000, 16'h0000, 16'd500);
        add_random_readings(100);
        wait_drained();

        // random thresholds
        write_reg(REG_COLOR_MARGIN, level_t'($urandom_range(60)));
        lo = level_t'($urandom_range(120));
        write_reg(REG_DARK_LOW, lo);
        write_reg(REG_DARK_HIGH, level_t'($urandom_range(255, lo)));
        write_reg(REG_UNUSED, level_t'($urandom_range(255)));
        add_random_readings(200);
        wait_drained();

        // back to the default thresholds, sender at full rate
        sender_idle_pct = 0;
        write_reg(REG_COLOR_MARGIN, 8'd15);
        write_reg(REG_DARK_LOW, 8'd25);
        write_reg(REG_DARK_HIGH, 8'd100);
        add_random_readings(200);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_calibrated_color_classifier_unit: PASS");
        else
            $display("tb_calibrated_color_classifier_unit: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ccc_pkg.sv
sv/ccc_scaler.sv
sv/ccc_classify.sv
sv/calibrated_color_classifier_unit.sv
sv/ccc_checker.sv
tb/tb_calibrated_color_classifier_unit.sv
